### hw/rtl/dq_pkg.sv
// Shared types, codes and widths for the double-ended queue.
package dq_pkg;

    // Field widths of the input and result beats.
    localparam int KIND_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Packed result beat: value, status, count and empty flag, padded to bytes.
    localparam int RES_W    = DATA_W + STATUS_W + COUNT_W + 1;
    localparam int RES_TW   = ((RES_W + 7) / 8) * 8;

    // Default number of slots in the ring store.
    localparam int DQ_DEPTH = 64;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_BACK  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd6;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // an input beat is accepted this cycle
        logic load;   // move the finished result into the output register
    } dq_cmd_t;

endpackage

### hw/rtl/dq_ram.sv
// Generic simple dual-port RAM with a registered read port.
module dq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/dq_ctrl.sv
// Controller: sequences accept, slot read and output register load.
module dq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output dq_pkg::dq_cmd_t cmd
);
    import dq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    // The output register is free when empty or drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    // Commands to the datapath.
    assign cmd.take = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.load = (state_reg == ST_LOAD) && out_free;

    // Next state and output valid.
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

### hw/rtl/dq_datapath.sv
// Datapath: ring positions, count, slot store and the result register.
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dq_pkg::dq_cmd_t             cmd,
    input  logic [dq_pkg::KIND_W-1:0]   kind,
    input  logic [dq_pkg::DATA_W-1:0]   value_in,
    output logic [dq_pkg::DATA_W-1:0]   value_out,
    output logic [dq_pkg::STATUS_W-1:0] status,
    output logic [dq_pkg::COUNT_W-1:0]  count,
    output logic                        is_empty
);
    import dq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int HW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
    localparam logic [HW-1:0] FULL_CNT = HW'(DEPTH);

    logic [PW-1:0]       front_reg, front_next;
    logic [PW-1:0]       back_reg, back_next;
    logic [HW-1:0]       held_reg, held_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                pend_read_reg, pend_read_next;

    logic [DATA_W-1:0]   value_out_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                is_empty_reg;

    logic [PW-1:0]       front_inc, front_dec, back_inc, back_dec;
    logic                empty_now, full_now;
    logic                wr_en, rd_en;
    logic [PW-1:0]       wr_addr, rd_addr;
    logic [DATA_W-1:0]   rd_data;

    // Ring neighbors of both positions.
    assign front_inc = (front_reg == LAST_POS) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - 1'b1;
    assign back_inc  = (back_reg == LAST_POS) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? LAST_POS : back_reg - 1'b1;

    assign empty_now = (held_reg == '0);
    assign full_now  = (held_reg == FULL_CNT);

    // Decode the operation and work out the next positions and count.
    always_comb
    begin
        front_next       = front_reg;
        back_next        = back_reg;
        held_next        = held_reg;
        pend_status_next = STATUS_OK;
        pend_read_next   = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = back_reg;
        rd_en            = 1'b0;
        rd_addr          = front_reg;
        if (cmd.take)
        begin
            unique case (kind)
                KIND_PUSH_FRONT:
                begin
                    if (full_now)
                    begin
                        pend_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        front_next = front_dec;
                        wr_en      = 1'b1;
                        wr_addr    = front_dec;
                        held_next  = held_reg + 1'b1;
                    end
                end
                KIND_PUSH_BACK:
                begin
                    if (full_now)
                    begin
                        pend_status_next = STATUS_FULL;
                    end
                    else
                    begin
                        back_next = back_inc;
                        wr_en     = 1'b1;
                        wr_addr   = back_reg;
                        held_next = held_reg + 1'b1;
                    end
                end
                KIND_POP_FRONT, KIND_PEEK_FRONT:
                begin
                    if (empty_now)
                    begin
                        pend_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = front_reg;
                        pend_read_next = 1'b1;
                        if (kind == KIND_POP_FRONT)
                        begin
                            front_next = front_inc;
                            held_next  = held_reg - 1'b1;
                        end
                    end
                end
                KIND_POP_BACK, KIND_PEEK_BACK:
                begin
                    if (empty_now)
                    begin
                        pend_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = back_dec;
                        pend_read_next = 1'b1;
                        if (kind == KIND_POP_BACK)
                        begin
                            back_next = back_dec;
                            held_next = held_reg - 1'b1;
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    front_next = '0;
                    back_next  = '0;
                    held_next  = '0;
                end
                default:
                begin
                    // Unused code: no change, report the current count.
                end
            endcase
        end
    end

    // Ring store of the queued words.
    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Positions and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            held_reg  <= held_next;
        end
    end

    // Result of the accepted beat, waiting for the slot read.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pend_status_reg <= pend_status_next;
            pend_read_reg   <= pend_read_next;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_out_reg <= pend_read_reg ? rd_data : '0;
            status_reg    <= pend_status_reg;
            count_reg     <= COUNT_W'(held_reg);
            is_empty_reg  <= (held_reg == '0);
        end
    end

    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign is_empty  = is_empty_reg;

endmodule

### hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: stream ports, controller and datapath.
//
// Double-ended queue of signed 32-bit words held in a ring of DEPTH slots.
// Each input beat carries one operation in s_tuser (push front, push back,
// pop front, pop back, peek front, peek back, clear) and the word to push
// in s_tdata; each beat yields exactly one result beat with the word read
// (zero when nothing is read), a status (ok, empty on pop or peek, full on
// push), the count after the operation (low 7 bits) and an empty flag. The
// edge that accepts an input beat also starts the registered read of the
// slot store, and the output register is loaded from ST_LOAD once it is
// free, so a stalled result beat holds the next result back. A new item
// is taken only after the previous result has been loaded; the next item
// is accepted while the previous result waits in the output register.
// Slots come up undefined and are only read after they have been written,
// so no clearing pass follows reset.
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [dq_pkg::DATA_W-1:0] s_tdata,  // [31:0] value_in
    input  logic [dq_pkg::KIND_W-1:0] s_tuser,  // [2:0] kind
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [31:0] value_out, [33:32] status, [40:34] count, [41] is_empty, rest zero
    output logic [dq_pkg::RES_TW-1:0] m_tdata
);
    import dq_pkg::*;

    dq_cmd_t             cmd;
    logic [DATA_W-1:0]   value_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;

    // Handshake sequencing.
    dq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Queue state and result.
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .kind      (s_tuser),
        .value_in  (s_tdata),
        .value_out (value_out),
        .status    (status),
        .count     (count),
        .is_empty  (is_empty)
    );

    // Pack the result beat.
    assign m_tdata = RES_TW'({is_empty, count, status, value_out});

endmodule

### hw/rtl/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
module dq_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [dq_pkg::RES_TW-1:0] m_tdata
);
    import dq_pkg::*;

    // A stalled result beat keeps its valid and its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Status is never the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[DATA_W+STATUS_W-1:DATA_W] <= STATUS_FULL)
        else $error("unused status code on result");

    // An error result carries a zero word.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[DATA_W+STATUS_W-1:DATA_W] != STATUS_OK
        |-> m_tdata[DATA_W-1:0] == '0)
        else $error("error result with a nonzero word");

    // An empty queue reports a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[RES_W-1]
        |-> m_tdata[RES_W-2:DATA_W+STATUS_W] == '0)
        else $error("empty flag with a nonzero count");

    // An accepted beat never yields a result in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared before the slot read finished");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### verif/double_ended_queue_tb.sv
// Self-checking testbench for the double-ended queue, driven through its stream ports.
`timescale 1ns / 1ps

module double_ended_queue_tb;

    import dq_pkg::*;

    // The one kind code that names no operation; the block answers it as a no-op.
    localparam logic [KIND_W-1:0] KIND_NOP = 3'd7;

    // Number of random operations after the directed part.
    localparam int RANDOM_OPS = 500;

    // One expected result beat, split into its fields.
    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     empty;
    } deque_result_t;

    // Mirror of the queue contents and the store of results still owed by the block.
    class deque_tracker;
        logic [DATA_W-1:0] slots [DQ_DEPTH];
        int                front_pos;
        int                back_pos;
        int                held;
        deque_result_t     pending_results[$];
        int                errors;
        int                beats_seen;
        int                pushes;
        int                refused;
        int                reads;
        int                empty_reads;
        int                clears;

        // Apply one accepted operation to the mirror and queue up its result.
        function void note_op(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] word);
            deque_result_t want;
            int            p;
            want.value  = '0;
            want.status = STATUS_OK;
            case (kind)
                KIND_PUSH_FRONT, KIND_PUSH_BACK:
                begin
                    pushes++;
                    if (held >= DQ_DEPTH) begin
                        want.status = STATUS_FULL;
                        refused++;
                    end else if (kind == KIND_PUSH_FRONT) begin
                        front_pos        = (front_pos + DQ_DEPTH - 1) % DQ_DEPTH;
                        slots[front_pos] = word;
                        held++;
                    end else begin
                        slots[back_pos] = word;
                        back_pos        = (back_pos + 1) % DQ_DEPTH;
                        held++;
                    end
                end
                KIND_POP_FRONT, KIND_PEEK_FRONT:
                begin
                    reads++;
                    if (held == 0) begin
                        want.status = STATUS_EMPTY;
                        empty_reads++;
                    end else begin
                        want.value = slots[front_pos];
                        if (kind == KIND_POP_FRONT) begin
                            front_pos = (front_pos + 1) % DQ_DEPTH;
                            held--;
                        end
                    end
                end
                KIND_POP_BACK, KIND_PEEK_BACK:
                begin
                    reads++;
                    if (held == 0) begin
                        want.status = STATUS_EMPTY;
                        empty_reads++;
                    end else begin
                        p          = (back_pos + DQ_DEPTH - 1) % DQ_DEPTH;
                        want.value = slots[p];
                        if (kind == KIND_POP_BACK) begin
                            back_pos = p;
                            held--;
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    clears++;
                    front_pos = 0;
                    back_pos  = 0;
                    held      = 0;
                end
                default:
                begin
                end
            endcase
            want.count = COUNT_W'(held);
            want.empty = (held == 0);
            pending_results.push_back(want);
        endfunction

        // Print one mismatch line and count it; printing stops after a while.
        task report(input string msg);
            if (errors < 50) begin
                $display("[%0t] mismatch on result beat %0d: %s", $time, beats_seen, msg);
            end
            errors++;
        endtask

        // Compare one result beat with the oldest expectation, field by field.
        task check_result(input logic [RES_TW-1:0] beat);
            deque_result_t want;
            beats_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result beat %h arrived with nothing expected", beat));
                return;
            end
            want = pending_results.pop_front();
            if (beat[DATA_W-1:0] !== want.value) begin
                report($sformatf("value %h, expected %h", beat[DATA_W-1:0], want.value));
            end
            if (beat[DATA_W +: STATUS_W] !== want.status) begin
                report($sformatf("status %0d, expected %0d", beat[DATA_W +: STATUS_W],
                                 want.status));
            end
            if (beat[DATA_W+STATUS_W +: COUNT_W] !== want.count) begin
                report($sformatf("count %0d, expected %0d", beat[DATA_W+STATUS_W +: COUNT_W],
                                 want.count));
            end
            if (beat[RES_W-1] !== want.empty) begin
                report($sformatf("empty flag %b, expected %b", beat[RES_W-1], want.empty));
            end
            if (beat[RES_TW-1:RES_W] !== '0) begin
                report($sformatf("padding bits %h are not zero", beat[RES_TW-1:RES_W]));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [DATA_W-1:0]   s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [RES_TW-1:0]   m_tdata;

    deque_tracker tracker;
    int           ops_sent;
    int           rx_hold_cycles;
    bit           tx_steady;
    bit           rx_steady;

    double_ended_queue i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Free-running clock, 8 ns period.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Idle length: mostly none, often short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    // Pushed words lean toward the extremes of the signed range.
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Operation mix for the free-running stretches.
    function automatic logic [KIND_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38) return ($urandom_range(0, 1) != 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        if (r < 68) return ($urandom_range(0, 1) != 0) ? KIND_POP_BACK : KIND_POP_FRONT;
        if (r < 95) return ($urandom_range(0, 1) != 0) ? KIND_PEEK_BACK : KIND_PEEK_FRONT;
        if (r < 97) return KIND_CLEAR;
        return KIND_NOP;
    endfunction

    // Offer one operation beat, wait for it to be taken, then idle for a random gap, none while tx_steady is set.
    task automatic issue(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] word);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        tracker.note_op(kind, word);
        if (kind != KIND_NOP) ops_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
    endtask

    // Result side: long hold-offs on request, otherwise random stalls unless rx_steady is set.
    initial begin : result_sink
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end else if (stall > 0 && !rx_steady) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = rx_steady ? 0 : pick_gap();
            end
        end
    end

    // Every beat taken from the result side goes to the checker.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            tracker.check_result(m_tdata);
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus.
    initial begin : stimulus
        int               n;
        logic [KIND_W-1:0] kind;
        tracker        = new;
        ops_sent       = 0;
        rx_hold_cycles = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = KIND_PUSH_FRONT;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reads on an empty queue, the no-op code, extreme words at both ends,
        // popping down to empty, and a clear with words still held.
        issue(KIND_POP_FRONT, pick_word());
        issue(KIND_POP_BACK, pick_word());
        issue(KIND_PEEK_FRONT, pick_word());
        issue(KIND_PEEK_BACK, pick_word());
        issue(KIND_NOP, pick_word());
        issue(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
        issue(KIND_PUSH_BACK, 32'h8000_0000);
        issue(KIND_PUSH_FRONT, 32'h0000_0000);
        issue(KIND_PUSH_BACK, 32'hFFFF_FFFF);
        issue(KIND_NOP, 32'hFFFF_FFFF);
        issue(KIND_PEEK_FRONT, pick_word());
        issue(KIND_PEEK_BACK, pick_word());
        issue(KIND_POP_FRONT, pick_word());
        issue(KIND_POP_BACK, pick_word());
        issue(KIND_POP_BACK, pick_word());
        issue(KIND_POP_FRONT, pick_word());
        issue(KIND_POP_FRONT, pick_word());
        issue(KIND_PUSH_BACK, 32'h5555_5555);
        issue(KIND_PUSH_BACK, 32'hAAAA_AAAA);
        issue(KIND_CLEAR, pick_word());
        issue(KIND_PEEK_BACK, pick_word());
        issue(KIND_PUSH_FRONT, pick_word());
        issue(KIND_POP_BACK, pick_word());
        wait_drained();

        // Back-pressure: the result side holds off while beats keep coming,
        // so the result stays in the output register and the block stops taking input.
        rx_hold_cycles = 160;
        tx_steady      = 1'b1;
        repeat (20) issue(KIND_PUSH_BACK, pick_word());
        tx_steady = 1'b0;
        wait_drained();
        ops_sent = 0;

        // Random runs: fill to full and beyond, drain toward empty with pops and peeks,
        // a clear after a pause, and mixed traffic, with idling switched on and off per run.
        while (ops_sent < RANDOM_OPS) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = DQ_DEPTH - tracker.held + $urandom_range(1, 3);
                    repeat (n) begin
                        kind = ($urandom_range(0, 1) != 0) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
                        issue(kind, pick_word());
                    end
                end
                2, 3:
                begin
                    n = tracker.held + $urandom_range(1, 3);
                    repeat (n) begin
                        case ($urandom_range(0, 5))
                            0:       kind = KIND_PEEK_FRONT;
                            1:       kind = KIND_PEEK_BACK;
                            2, 3:    kind = KIND_POP_FRONT;
                            default: kind = KIND_POP_BACK;
                        endcase
                        issue(kind, pick_word());
                    end
                end
                4:
                begin
                    // Pause until the block has answered everything.
                    wait_drained();
                    issue(KIND_CLEAR, pick_word());
                    issue(pick_kind(), pick_word());
                end
                default:
                begin
                    repeat ($urandom_range(4, 20)) issue(pick_kind(), pick_word());
                end
            endcase
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.pending_results.size() != 0) begin
            tracker.report("results still expected at the end of the run");
        end

        $display("Checked %0d result beats: %0d pushes (%0d refused as full), %0d pops or peeks",
                 tracker.beats_seen, tracker.pushes, tracker.refused, tracker.reads);
        $display("(%0d of them on an empty queue) and %0d clears; %0d mismatches.",
                 tracker.empty_reads, tracker.clears, tracker.errors);
        if (tracker.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
